// ===== sv/rk4hts_pkg.sv =====
// Package for the helix track stepper: widths, payload structs, multiplier
// request, microcode word format and the microcode program itself.
// No dependencies.
`timescale 1ns / 1ps

package rk4hts_pkg;

  // Number format and track limits
  localparam int FRAC_BITS = 32;
  localparam int MAX_STEPS = 100000;
  localparam int DATA_W    = 48;
  localparam int STEP_W    = 17;
  localparam int PHASE_W   = 16;
  localparam int ACC_W     = 51;           // k1 + 2k2 + 2k3 + k4 without overflow
  localparam int ZLIM_W    = 47;
  localparam int HSTEP_W   = 47;

  // Shared multiplier: unsigned magnitudes, split into two halves
  localparam int MAG_W     = 50;
  localparam int HALF_W    = MAG_W / 2;
  localparam int PROD_W    = 2 * MAG_W;

  // Divide by three through a reciprocal: q = (n * DIV_RECIP) >> DIV_SHIFT
  localparam int DIV_SHIFT = 51;
  localparam logic [MAG_W-1:0] DIV_RECIP = MAG_W'(((64'd1 << DIV_SHIFT) + 64'd1) / 64'd3);

  // Configuration register indexes
  localparam int CFG_W = 3;
  localparam logic [CFG_W-1:0] CFG_FIELD_COEF  = 3'd0;
  localparam logic [CFG_W-1:0] CFG_STEP_SIZE   = 3'd1;
  localparam logic [CFG_W-1:0] CFG_VEL_X_INIT  = 3'd2;
  localparam logic [CFG_W-1:0] CFG_VEL_Y_INIT  = 3'd3;
  localparam logic [CFG_W-1:0] CFG_VEL_Z_CONST = 3'd4;
  localparam logic [CFG_W-1:0] CFG_SAMPLE_INTV = 3'd5;
  localparam logic [CFG_W-1:0] CFG_Z_LIMIT     = 3'd6;

  // Configuration reset values
  localparam logic [HSTEP_W-1:0] STEP_SIZE_RST = 47'd42950;
  localparam logic [PHASE_W-1:0] SAMPLE_INTV_RST = 16'd20;
  localparam logic [ZLIM_W-1:0]  Z_LIMIT_RST = 47'd21474836480;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    logic  start_req;
    word_t start_x;
    word_t start_y;
    word_t start_z;
  } in_item_t;

  typedef struct packed {
    word_t             pos_x;
    word_t             pos_y;
    word_t             pos_z;
    logic [STEP_W-1:0] step_index;
    logic              track_end;
  } out_item_t;

  // Multiplier unit request
  typedef enum logic {
    MUL_QMUL,   // round by FRAC_BITS, saturate
    MUL_DIV3    // reciprocal divide, truncate
  } mul_mode_e;

  typedef struct packed {
    logic             start;
    mul_mode_e        mode;
    logic             neg;
    logic [MAG_W-1:0] a_mag;
    logic [MAG_W-1:0] b_mag;
  } mul_req_t;

  // Microcode word
  localparam int PC_W = 6;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ADD,     // dst = sat(a + b)
    OP_SUB,     // dst = sat(a - b)
    OP_ADDH,    // dst = sat(a + b/2), halving truncates toward zero
    OP_MUL,     // dst = qmul(a, b) on the shared multiplier
    OP_DIVX,    // dst = round(sum_k / 6)
    OP_DIVY,    // dst = round(sum_l / 6)
    OP_WAIT,    // take an input transfer
    OP_FIN,     // step bookkeeping and result
    OP_START    // load a new track and report it
  } op_e;

  typedef enum logic [3:0] {
    SRC_CX, SRC_CY, SRC_CZ, SRC_RX, SRC_RY, SRC_AX, SRC_AY, SRC_T,
    SRC_KK, SRC_LL, SRC_F, SRC_H, SRC_VXI, SRC_VYI, SRC_VZ
  } src_e;

  typedef enum logic [3:0] {
    DST_NONE, DST_CX, DST_CY, DST_CZ, DST_AX, DST_AY, DST_T, DST_KK, DST_LL
  } dst_e;

  typedef enum logic [1:0] {
    ACC_NONE,   // leave the weighted sums
    ACC_SET,    // sums = k, l
    ACC_ADD2,   // sums += 2k, 2l
    ACC_ADD1    // sums += k, l
  } acc_e;

  typedef enum logic [1:0] {
    CND_NEXT,   // fall through
    CND_ALWAYS, // jump
    CND_START   // jump when the accepted item is a start
  } cond_e;

  typedef struct packed {
    op_e              op;
    src_e             src_a;
    src_e             src_b;
    dst_e             dst;
    acc_e             acc;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } uword_t;

  localparam logic [PC_W-1:0] UPC_WAIT  = 6'd0;
  localparam logic [PC_W-1:0] UPC_START = 6'd47;

  // Microcode program. Each RK stage: velocity terms through the field
  // coefficient, scale by h, then form next stage arguments (stages 1-3).
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] upc);
    uword_t w;
    unique case (upc)
      6'd0:  w = '{OP_WAIT,  SRC_T,   SRC_T,  DST_NONE, ACC_NONE, CND_START,  UPC_START};
      // stage 1, arguments are the current position
      6'd1:  w = '{OP_SUB,   SRC_CY,  SRC_RY, DST_T,    ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd2:  w = '{OP_MUL,   SRC_F,   SRC_T,  DST_T,    ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd3:  w = '{OP_ADD,   SRC_T,   SRC_VXI, DST_T,   ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd4:  w = '{OP_MUL,   SRC_H,   SRC_T,  DST_KK,   ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd5:  w = '{OP_SUB,   SRC_CX,  SRC_RX, DST_T,    ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd6:  w = '{OP_MUL,   SRC_F,   SRC_T,  DST_T,    ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd7:  w = '{OP_SUB,   SRC_VYI, SRC_T,  DST_T,    ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd8:  w = '{OP_MUL,   SRC_H,   SRC_T,  DST_LL,   ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd9:  w = '{OP_ADDH,  SRC_CY,  SRC_LL, DST_AY,   ACC_SET,  CND_NEXT,   UPC_WAIT};
      6'd10: w = '{OP_ADDH,  SRC_CX,  SRC_KK, DST_AX,   ACC_NONE, CND_NEXT,   UPC_WAIT};
      // stage 2
      6'd11: w = '{OP_SUB,   SRC_AY,  SRC_RY, DST_T,    ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd12: w = '{OP_MUL,   SRC_F,   SRC_T,  DST_T,    ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd13: w = '{OP_ADD,   SRC_T,   SRC_VXI, DST_T,   ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd14: w = '{OP_MUL,   SRC_H,   SRC_T,  DST_KK,   ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd15: w = '{OP_SUB,   SRC_AX,  SRC_RX, DST_T,    ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd16: w = '{OP_MUL,   SRC_F,   SRC_T,  DST_T,    ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd17: w = '{OP_SUB,   SRC_VYI, SRC_T,  DST_T,    ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd18: w = '{OP_MUL,   SRC_H,   SRC_T,  DST_LL,   ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd19: w = '{OP_ADDH,  SRC_CY,  SRC_LL, DST_AY,   ACC_ADD2, CND_NEXT,   UPC_WAIT};
      6'd20: w = '{OP_ADDH,  SRC_CX,  SRC_KK, DST_AX,   ACC_NONE, CND_NEXT,   UPC_WAIT};
      // stage 3, next arguments take the full stage value
      6'd21: w = '{OP_SUB,   SRC_AY,  SRC_RY, DST_T,    ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd22: w = '{OP_MUL,   SRC_F,   SRC_T,  DST_T,    ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd23: w = '{OP_ADD,   SRC_T,   SRC_VXI, DST_T,   ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd24: w = '{OP_MUL,   SRC_H,   SRC_T,  DST_KK,   ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd25: w = '{OP_SUB,   SRC_AX,  SRC_RX, DST_T,    ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd26: w = '{OP_MUL,   SRC_F,   SRC_T,  DST_T,    ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd27: w = '{OP_SUB,   SRC_VYI, SRC_T,  DST_T,    ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd28: w = '{OP_MUL,   SRC_H,   SRC_T,  DST_LL,   ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd29: w = '{OP_ADD,   SRC_CY,  SRC_LL, DST_AY,   ACC_ADD2, CND_NEXT,   UPC_WAIT};
      6'd30: w = '{OP_ADD,   SRC_CX,  SRC_KK, DST_AX,   ACC_NONE, CND_NEXT,   UPC_WAIT};
      // stage 4
      6'd31: w = '{OP_SUB,   SRC_AY,  SRC_RY, DST_T,    ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd32: w = '{OP_MUL,   SRC_F,   SRC_T,  DST_T,    ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd33: w = '{OP_ADD,   SRC_T,   SRC_VXI, DST_T,   ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd34: w = '{OP_MUL,   SRC_H,   SRC_T,  DST_KK,   ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd35: w = '{OP_SUB,   SRC_AX,  SRC_RX, DST_T,    ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd36: w = '{OP_MUL,   SRC_F,   SRC_T,  DST_T,    ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd37: w = '{OP_SUB,   SRC_VYI, SRC_T,  DST_T,    ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd38: w = '{OP_MUL,   SRC_H,   SRC_T,  DST_LL,   ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd39: w = '{OP_NOP,   SRC_T,   SRC_T,  DST_NONE, ACC_ADD1, CND_NEXT,   UPC_WAIT};
      // combine and the z step
      6'd40: w = '{OP_DIVX,  SRC_T,   SRC_T,  DST_T,    ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd41: w = '{OP_ADD,   SRC_CX,  SRC_T,  DST_CX,   ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd42: w = '{OP_DIVY,  SRC_T,   SRC_T,  DST_T,    ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd43: w = '{OP_ADD,   SRC_CY,  SRC_T,  DST_CY,   ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd44: w = '{OP_MUL,   SRC_H,   SRC_VZ, DST_T,    ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd45: w = '{OP_ADD,   SRC_CZ,  SRC_T,  DST_CZ,   ACC_NONE, CND_NEXT,   UPC_WAIT};
      6'd46: w = '{OP_FIN,   SRC_T,   SRC_T,  DST_NONE, ACC_NONE, CND_ALWAYS, UPC_WAIT};
      6'd47: w = '{OP_START, SRC_T,   SRC_T,  DST_NONE, ACC_NONE, CND_ALWAYS, UPC_WAIT};
      default: w = '{OP_NOP, SRC_T,   SRC_T,  DST_NONE, ACC_NONE, CND_ALWAYS, UPC_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/rk4hts_mul.sv =====
// Shared iterative multiplier of the helix track stepper: unsigned magnitude
// product from four half-width partial products, then rounding or reciprocal
// scaling and signed saturation. Depends on rk4hts_pkg.
`timescale 1ns / 1ps

module rk4hts_mul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rk4hts_pkg::mul_req_t req_i,
  output logic                 done_o,
  output rk4hts_pkg::word_t    res_o
);
  import rk4hts_pkg::*;

  localparam logic [2:0] CNT_LAST_PP = 3'd3;
  localparam logic [2:0] CNT_FINISH  = 3'd5;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [PROD_W-1:0] POS_LIM = (PROD_W'(1) << (DATA_W - 1)) - PROD_W'(1);
  localparam logic [PROD_W-1:0] NEG_LIM = PROD_W'(1) << (DATA_W - 1);

  logic                  busy_q, busy_d;
  logic [2:0]            cnt_q, cnt_d;
  logic                  ppv_q, ppv_d;
  logic                  done_q, done_d;

  logic [MAG_W-1:0]      a_q, a_d, b_q, b_d;
  logic                  neg_q, neg_d;
  mul_mode_e             mode_q, mode_d;
  logic [PROD_W-1:0]     acc_q, acc_d;
  logic [2*HALF_W-1:0]   pp_q, pp_d;
  logic [1:0]            sh_q, sh_d;
  word_t                 res_q, res_d;

  logic [HALF_W-1:0]     a_part, b_part;
  logic [PROD_W-1:0]     pp_shifted;
  logic [PROD_W-1:0]     rounded, scaled, lim, clamped;

  // partial product select and alignment
  always_comb begin
    a_part = cnt_q[1] ? a_q[MAG_W-1:HALF_W] : a_q[HALF_W-1:0];
    b_part = cnt_q[0] ? b_q[MAG_W-1:HALF_W] : b_q[HALF_W-1:0];
    unique case (sh_q)
      2'd0:    pp_shifted = PROD_W'(pp_q);
      2'd1:    pp_shifted = PROD_W'(pp_q) << HALF_W;
      2'd2:    pp_shifted = PROD_W'(pp_q) << (2 * HALF_W);
      default: pp_shifted = '0;
    endcase
  end

  // final scaling and saturation
  always_comb begin
    rounded = acc_q + ROUND_HALF;
    scaled  = (mode_q == MUL_DIV3) ? (acc_q >> DIV_SHIFT) : (rounded >> FRAC_BITS);
    lim     = neg_q ? NEG_LIM : POS_LIM;
    clamped = (scaled > lim) ? lim : scaled;
    res_d   = neg_q ? -clamped[DATA_W-1:0] : clamped[DATA_W-1:0];
  end

  // iteration control
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    ppv_d  = ppv_q;
    done_d = 1'b0;
    a_d    = a_q;
    b_d    = b_q;
    neg_d  = neg_q;
    mode_d = mode_q;
    acc_d  = acc_q;
    pp_d   = pp_q;
    sh_d   = sh_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      ppv_d  = 1'b0;
      a_d    = req_i.a_mag;
      b_d    = req_i.b_mag;
      neg_d  = req_i.neg;
      mode_d = req_i.mode;
      acc_d  = '0;
    end else if (busy_q) begin
      if (cnt_q <= CNT_LAST_PP) begin
        pp_d  = (2*HALF_W)'(a_part) * (2*HALF_W)'(b_part);
        sh_d  = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
        ppv_d = 1'b1;
      end else begin
        ppv_d = 1'b0;
      end
      if (ppv_q) begin
        acc_d = acc_q + pp_shifted;
      end
      if (cnt_q == CNT_FINISH) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      ppv_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      ppv_q  <= ppv_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    neg_q  <= neg_d;
    mode_q <= mode_d;
    acc_q  <= acc_d;
    pp_q   <= pp_d;
    sh_q   <= sh_d;
    if (busy_q && (cnt_q == CNT_FINISH)) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== sv/rk4_helix_track_stepper.sv =====
// Helix track stepper top level: microcode sequencer, register datapath,
// configuration registers and output register.
// Depends on rk4hts_pkg and rk4hts_mul.
`timescale 1ns / 1ps

// Steps a charged track through a uniform axial field with a fourth-order
// Runge-Kutta step in Q16.32. A start transfer loads the track and reports
// it once the output register is free. After a tick, no item is taken until
// the microcode program has run its 46 steps, 19 of them on the shared
// multiplier (four 25x25 partial products, accumulate, scale). A tick on an
// idle track is taken and dropped. A result sits in the output register while
// the next tick is worked on; a step that must report waits only if that
// register is still held. The user must write configuration only while no
// item is in work; the block does not enforce it.
module rk4_helix_track_stepper (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  rk4hts_pkg::in_item_t                in_data_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output rk4hts_pkg::out_item_t               out_data_o,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [rk4hts_pkg::CFG_W-1:0]        cfg_idx_i,
  input  logic [rk4hts_pkg::DATA_W-1:0]       cfg_data_i
);
  import rk4hts_pkg::*;

  // configuration
  word_t                 fcoef_q, fcoef_d;
  logic [HSTEP_W-1:0]    hstep_q, hstep_d;
  word_t                 vxi_q, vxi_d, vyi_q, vyi_d, vz_q, vz_d;
  logic [PHASE_W-1:0]    sintv_q, sintv_d;
  logic [ZLIM_W-1:0]     zlim_q, zlim_d;

  // control
  logic [PC_W-1:0]       upc_q, upc_d;
  logic                  issued_q, issued_d;
  logic                  active_q, active_d;
  logic [STEP_W-1:0]     steps_q, steps_d;
  logic [PHASE_W-1:0]    phase_q, phase_d;
  logic                  out_valid_q, out_valid_d;

  // datapath
  word_t                 cx_q, cx_d, cy_q, cy_d, cz_q, cz_d, rx_q, rx_d, ry_q, ry_d;
  word_t                 ax_q, ax_d, ay_q, ay_d, t_q, t_d, kk_q, kk_d, ll_q, ll_d;
  logic signed [ACC_W-1:0] sk_q, sk_d, sl_q, sl_d;
  out_item_t             out_q, out_d;

  uword_t                uw;
  word_t                 op_a, op_b, alu_res, dst_val;
  logic signed [DATA_W:0] sum_add, sum_sub, half_tmp, sum_half;
  word_t                 half_b;
  logic [DATA_W-1:0]     mag_a, mag_b;
  logic signed [ACC_W-1:0] div_src, div_mag;
  logic [ACC_W-1:0]      div_plus;
  logic                  is_mul, is_div;
  mul_req_t              mul_req;
  logic                  mul_done;
  word_t                 mul_res;

  logic                  in_xfer, out_free, step_done, take_jump;
  logic [STEP_W-1:0]     steps_inc;
  logic [DATA_W-1:0]     z_abs;
  logic [PHASE_W-1:0]    intv, phase_inc;
  logic                  end_hit, sample_hit, need_emit, emit;

  function automatic word_t sat48(input logic signed [DATA_W:0] s);
    word_t r;
    if (s[DATA_W] != s[DATA_W-1]) begin
      r = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = s[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] abs48(input word_t v);
    return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
  endfunction

  rk4hts_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  assign uw = ucode_rom(upc_q);

  // operand select
  always_comb begin
    unique case (uw.src_a)
      SRC_CX:  op_a = cx_q;
      SRC_CY:  op_a = cy_q;
      SRC_CZ:  op_a = cz_q;
      SRC_RX:  op_a = rx_q;
      SRC_RY:  op_a = ry_q;
      SRC_AX:  op_a = ax_q;
      SRC_AY:  op_a = ay_q;
      SRC_T:   op_a = t_q;
      SRC_KK:  op_a = kk_q;
      SRC_LL:  op_a = ll_q;
      SRC_F:   op_a = fcoef_q;
      SRC_H:   op_a = {1'b0, hstep_q};
      SRC_VXI: op_a = vxi_q;
      SRC_VYI: op_a = vyi_q;
      SRC_VZ:  op_a = vz_q;
      default: op_a = '0;
    endcase
    unique case (uw.src_b)
      SRC_CX:  op_b = cx_q;
      SRC_CY:  op_b = cy_q;
      SRC_CZ:  op_b = cz_q;
      SRC_RX:  op_b = rx_q;
      SRC_RY:  op_b = ry_q;
      SRC_AX:  op_b = ax_q;
      SRC_AY:  op_b = ay_q;
      SRC_T:   op_b = t_q;
      SRC_KK:  op_b = kk_q;
      SRC_LL:  op_b = ll_q;
      SRC_F:   op_b = fcoef_q;
      SRC_H:   op_b = {1'b0, hstep_q};
      SRC_VXI: op_b = vxi_q;
      SRC_VYI: op_b = vyi_q;
      SRC_VZ:  op_b = vz_q;
      default: op_b = '0;
    endcase
  end

  // saturating adder, halving truncates toward zero
  always_comb begin
    sum_add  = {op_a[DATA_W-1], op_a} + {op_b[DATA_W-1], op_b};
    sum_sub  = {op_a[DATA_W-1], op_a} - {op_b[DATA_W-1], op_b};
    half_tmp = {op_b[DATA_W-1], op_b} + (DATA_W+1)'(op_b[DATA_W-1]);
    half_b   = half_tmp[DATA_W:1];
    sum_half = {op_a[DATA_W-1], op_a} + {half_b[DATA_W-1], half_b};
    unique case (uw.op)
      OP_ADD:  alu_res = sat48(sum_add);
      OP_SUB:  alu_res = sat48(sum_sub);
      OP_ADDH: alu_res = sat48(sum_half);
      default: alu_res = sat48(sum_add);
    endcase
  end

  // multiplier request: products of signed words, or round(sum / 6) as
  // ((|s| + 3) >> 1) / 3 through the reciprocal
  always_comb begin
    is_div   = (uw.op == OP_DIVX) || (uw.op == OP_DIVY);
    is_mul   = (uw.op == OP_MUL) || is_div;
    mag_a    = abs48(op_a);
    mag_b    = abs48(op_b);
    div_src  = (uw.op == OP_DIVY) ? sl_q : sk_q;
    div_mag  = div_src[ACC_W-1] ? -div_src : div_src;
    div_plus = div_mag + ACC_W'(3);
    mul_req.start = is_mul && !issued_q;
    if (is_div) begin
      mul_req.mode  = MUL_DIV3;
      mul_req.neg   = div_src[ACC_W-1];
      mul_req.a_mag = MAG_W'(div_plus[ACC_W-1:1]);
      mul_req.b_mag = DIV_RECIP;
    end else begin
      mul_req.mode  = MUL_QMUL;
      mul_req.neg   = op_a[DATA_W-1] ^ op_b[DATA_W-1];
      mul_req.a_mag = MAG_W'(mag_a);
      mul_req.b_mag = MAG_W'(mag_b);
    end
  end

  // end of step checks
  always_comb begin
    steps_inc  = (steps_q == '1) ? steps_q : steps_q + STEP_W'(1);
    z_abs      = abs48(cz_q);
    end_hit    = (z_abs > {1'b0, zlim_q}) || (steps_inc >= STEP_W'(MAX_STEPS));
    intv       = (sintv_q == '0) ? PHASE_W'(1) : sintv_q;
    phase_inc  = phase_q + PHASE_W'(1);
    sample_hit = (phase_inc >= intv) || (phase_inc == '0);
    need_emit  = end_hit || sample_hit;
  end

  assign in_stall_o = (upc_q != UPC_WAIT);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // sequencer: step completion and next address
  always_comb begin
    unique case (uw.op)
      OP_WAIT:  step_done = in_xfer && (in_data_i.start_req || active_q);
      OP_MUL,
      OP_DIVX,
      OP_DIVY:  step_done = issued_q && mul_done;
      OP_FIN:   step_done = !need_emit || out_free;
      OP_START: step_done = out_free;
      default:  step_done = 1'b1;
    endcase
    unique case (uw.cond)
      CND_ALWAYS: take_jump = 1'b1;
      CND_START:  take_jump = in_data_i.start_req;
      default:    take_jump = 1'b0;
    endcase
    if (step_done) begin
      upc_d = take_jump ? uw.target : upc_q + PC_W'(1);
    end else begin
      upc_d = upc_q;
    end
    if (is_mul) begin
      issued_d = issued_q ? !mul_done : 1'b1;
    end else begin
      issued_d = 1'b0;
    end
  end

  // datapath writes, bookkeeping and output register
  always_comb begin
    cx_d = cx_q; cy_d = cy_q; cz_d = cz_q; rx_d = rx_q; ry_d = ry_q;
    ax_d = ax_q; ay_d = ay_q; t_d = t_q; kk_d = kk_q; ll_d = ll_q;
    sk_d = sk_q; sl_d = sl_q;
    active_d = active_q;
    steps_d  = steps_q;
    phase_d  = phase_q;
    emit     = 1'b0;
    out_d    = out_q;
    dst_val  = is_mul ? mul_res : alu_res;

    if (step_done) begin
      unique case (uw.dst)
        DST_CX:  cx_d = dst_val;
        DST_CY:  cy_d = dst_val;
        DST_CZ:  cz_d = dst_val;
        DST_AX:  ax_d = dst_val;
        DST_AY:  ay_d = dst_val;
        DST_T:   t_d  = dst_val;
        DST_KK:  kk_d = dst_val;
        DST_LL:  ll_d = dst_val;
        default: ;
      endcase

      // weighted stage sums
      unique case (uw.acc)
        ACC_SET: begin
          sk_d = ACC_W'(kk_q);
          sl_d = ACC_W'(ll_q);
        end
        ACC_ADD2: begin
          sk_d = sk_q + (ACC_W'(kk_q) <<< 1);
          sl_d = sl_q + (ACC_W'(ll_q) <<< 1);
        end
        ACC_ADD1: begin
          sk_d = sk_q + ACC_W'(kk_q);
          sl_d = sl_q + ACC_W'(ll_q);
        end
        default: ;
      endcase

      unique case (uw.op)
        // hold a start position until the report slot is free
        OP_WAIT: begin
          if (in_data_i.start_req) begin
            ax_d = in_data_i.start_x;
            ay_d = in_data_i.start_y;
            t_d  = in_data_i.start_z;
          end
        end
        OP_START: begin
          cx_d     = ax_q;
          rx_d     = ax_q;
          cy_d     = ay_q;
          ry_d     = ay_q;
          cz_d     = t_q;
          steps_d  = '0;
          phase_d  = '0;
          active_d = 1'b1;
          emit     = 1'b1;
          out_d    = '{pos_x: ax_q, pos_y: ay_q, pos_z: t_q,
                       step_index: '0, track_end: 1'b0};
        end
        OP_FIN: begin
          steps_d = steps_inc;
          emit    = need_emit;
          // a silent step leaves a held result alone
          if (need_emit) begin
            out_d = '{pos_x: cx_q, pos_y: cy_q, pos_z: cz_q,
                      step_index: steps_inc, track_end: end_hit};
          end
          if (end_hit) begin
            active_d = 1'b0;
          end else if (sample_hit) begin
            phase_d = '0;
          end else begin
            phase_d = phase_inc;
          end
        end
        default: ;
      endcase
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // configuration writes
  always_comb begin
    fcoef_d = fcoef_q;
    hstep_d = hstep_q;
    vxi_d   = vxi_q;
    vyi_d   = vyi_q;
    vz_d    = vz_q;
    sintv_d = sintv_q;
    zlim_d  = zlim_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FIELD_COEF:  fcoef_d = cfg_data_i;
        CFG_STEP_SIZE:   hstep_d = cfg_data_i[HSTEP_W-1:0];
        CFG_VEL_X_INIT:  vxi_d   = cfg_data_i;
        CFG_VEL_Y_INIT:  vyi_d   = cfg_data_i;
        CFG_VEL_Z_CONST: vz_d    = cfg_data_i;
        CFG_SAMPLE_INTV: sintv_d = cfg_data_i[PHASE_W-1:0];
        CFG_Z_LIMIT:     zlim_d  = cfg_data_i[ZLIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcoef_q     <= '0;
      hstep_q     <= STEP_SIZE_RST;
      vxi_q       <= '0;
      vyi_q       <= '0;
      vz_q        <= '0;
      sintv_q     <= SAMPLE_INTV_RST;
      zlim_q      <= Z_LIMIT_RST;
      upc_q       <= UPC_WAIT;
      issued_q    <= 1'b0;
      active_q    <= 1'b0;
      steps_q     <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fcoef_q     <= fcoef_d;
      hstep_q     <= hstep_d;
      vxi_q       <= vxi_d;
      vyi_q       <= vyi_d;
      vz_q        <= vz_d;
      sintv_q     <= sintv_d;
      zlim_q      <= zlim_d;
      upc_q       <= upc_d;
      issued_q    <= issued_d;
      active_q    <= active_d;
      steps_q     <= steps_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q  <= cx_d;
    cy_q  <= cy_d;
    cz_q  <= cz_d;
    rx_q  <= rx_d;
    ry_q  <= ry_d;
    ax_q  <= ax_d;
    ay_q  <= ay_d;
    t_q   <= t_d;
    kk_q  <= kk_d;
    ll_q  <= ll_d;
    sk_q  <= sk_d;
    sl_q  <= sl_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/rk4hts_track_checker.sv =====
// Scoreboard for the helix track stepper: watches the configuration port and
// both channels, predicts every report and compares it on arrival.
// Depends on rk4hts_pkg.
`timescale 1ns / 1ps

module rk4hts_track_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  rk4hts_pkg::in_item_t          in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  rk4hts_pkg::out_item_t         out_data_i,
  input  logic                          cfg_we_i,
  input  logic [rk4hts_pkg::CFG_W-1:0]  cfg_idx_i,
  input  logic [rk4hts_pkg::DATA_W-1:0] cfg_data_i,
  output int                            err_count_o,
  output int                            pending_o,
  output int                            worked_o
);
  import rk4hts_pkg::*;

  localparam longint Q_MAX = (longint'(1) << (DATA_W - 1)) - 1;
  localparam longint Q_MIN = -(longint'(1) << (DATA_W - 1));

  // shadow settings
  longint      coef, step_h, vel_x0, vel_y0, vel_z, z_lim;
  int unsigned interval;

  // shadow track state
  longint      pos_x, pos_y, pos_z, ref_x, ref_y;
  int unsigned steps, phase;
  bit          active;

  out_item_t   track_reports_q[$];
  out_item_t   want;
  int          mismatches;
  int          worked;

  function automatic longint clamp48(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // exact product, rounded half away from zero, saturated
  function automatic longint fx_mul(input longint a, input longint b);
    logic [127:0] ma, mb, prod, lim;
    bit           neg;
    longint       r;
    neg  = (a < 0) != (b < 0);
    ma   = (a < 0) ? 128'(-a) : 128'(a);
    mb   = (b < 0) ? 128'(-b) : 128'(b);
    prod = (ma * mb + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim  = neg ? 128'(Q_MAX) + 128'd1 : 128'(Q_MAX);
    if (prod > lim) prod = lim;
    r = longint'(prod[63:0]);
    return neg ? -r : r;
  endfunction

  function automatic longint drift_x(input longint y);
    return clamp48(fx_mul(coef, clamp48(y - ref_y)) + vel_x0);
  endfunction

  function automatic longint drift_y(input longint x);
    return clamp48(vel_y0 - fx_mul(coef, clamp48(x - ref_x)));
  endfunction

  // weighted stage sum over six, rounded half away from zero
  function automatic longint blend(input longint p, input longint s1, input longint s2,
                                   input longint s3, input longint s4);
    longint s, m, q;
    s = s1 + 2 * s2 + 2 * s3 + s4;
    m = (s < 0) ? -s : s;
    q = (m + 3) / 6;
    return clamp48(p + ((s < 0) ? -q : q));
  endfunction

  task automatic post_report(input bit last);
    out_item_t r;
    r.pos_x      = pos_x[DATA_W-1:0];
    r.pos_y      = pos_y[DATA_W-1:0];
    r.pos_z      = pos_z[DATA_W-1:0];
    r.step_index = steps[STEP_W-1:0];
    r.track_end  = last;
    track_reports_q.push_back(r);
  endtask

  // one accepted input: a start, or a single RK4 step
  task automatic advance_track(input in_item_t it);
    longint      k1, k2, k3, k4, l1, l2, l3, l4, az;
    int unsigned every;
    if (it.start_req) begin
      pos_x  = longint'(it.start_x);
      pos_y  = longint'(it.start_y);
      pos_z  = longint'(it.start_z);
      ref_x  = pos_x;
      ref_y  = pos_y;
      steps  = 0;
      phase  = 0;
      active = 1'b1;
      post_report(1'b0);
    end else if (active) begin
      k1 = fx_mul(step_h, drift_x(pos_y));
      l1 = fx_mul(step_h, drift_y(pos_x));
      k2 = fx_mul(step_h, drift_x(clamp48(pos_y + l1 / 2)));
      l2 = fx_mul(step_h, drift_y(clamp48(pos_x + k1 / 2)));
      k3 = fx_mul(step_h, drift_x(clamp48(pos_y + l2 / 2)));
      l3 = fx_mul(step_h, drift_y(clamp48(pos_x + k2 / 2)));
      k4 = fx_mul(step_h, drift_x(clamp48(pos_y + l3)));
      l4 = fx_mul(step_h, drift_y(clamp48(pos_x + k3)));
      pos_x = blend(pos_x, k1, k2, k3, k4);
      pos_y = blend(pos_y, l1, l2, l3, l4);
      pos_z = clamp48(pos_z + fx_mul(step_h, vel_z));
      if (steps < 32'h1FFFF) steps++;
      az = (pos_z < 0) ? -pos_z : pos_z;
      if (az > z_lim || steps >= MAX_STEPS) begin
        // end of track takes the place of any sample
        active = 1'b0;
        post_report(1'b1);
      end else begin
        every = (interval == 0) ? 1 : interval;
        phase = (phase + 1) & 32'hFFFF;
        if (phase >= every || phase == 0) begin
          phase = 0;
          post_report(1'b0);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef     = 0;
      step_h   = longint'(STEP_SIZE_RST);
      vel_x0   = 0;
      vel_y0   = 0;
      vel_z    = 0;
      interval = SAMPLE_INTV_RST;
      z_lim    = longint'(Z_LIMIT_RST);
      pos_x    = 0;
      pos_y    = 0;
      pos_z    = 0;
      ref_x    = 0;
      ref_y    = 0;
      steps    = 0;
      phase    = 0;
      active   = 1'b0;
      track_reports_q.delete();
    end else begin
      // register writes; unused indexes fall through
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FIELD_COEF:  coef     = longint'($signed(cfg_data_i));
          CFG_STEP_SIZE:   step_h   = longint'(cfg_data_i[HSTEP_W-1:0]);
          CFG_VEL_X_INIT:  vel_x0   = longint'($signed(cfg_data_i));
          CFG_VEL_Y_INIT:  vel_y0   = longint'($signed(cfg_data_i));
          CFG_VEL_Z_CONST: vel_z    = longint'($signed(cfg_data_i));
          CFG_SAMPLE_INTV: interval = cfg_data_i[PHASE_W-1:0];
          CFG_Z_LIMIT:     z_lim    = longint'(cfg_data_i[ZLIM_W-1:0]);
          default: ;
        endcase
      end

      // result transfer against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (track_reports_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result x=%h y=%h z=%h step=%0d end=%0b", $time,
                     out_data_i.pos_x, out_data_i.pos_y, out_data_i.pos_z,
                     out_data_i.step_index, out_data_i.track_end);
        end else begin
          want = track_reports_q.pop_front();
          if (want.pos_x !== out_data_i.pos_x || want.pos_y !== out_data_i.pos_y ||
              want.pos_z !== out_data_i.pos_z ||
              want.step_index !== out_data_i.step_index ||
              want.track_end !== out_data_i.track_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch want x=%h y=%h z=%h step=%0d end=%0b",
                       $time, want.pos_x, want.pos_y, want.pos_z, want.step_index,
                       want.track_end, "\n    got x=%h y=%h z=%h step=%0d end=%0b",
                       out_data_i.pos_x, out_data_i.pos_y, out_data_i.pos_z,
                       out_data_i.step_index, out_data_i.track_end);
          end
        end
      end

      // input transfer; every accepted item counts, dropped ticks too
      if (in_valid_i && !in_stall_i) begin
        worked++;
        advance_track(in_data_i);
      end
    end
    err_count_o <= mismatches;
    pending_o   <= track_reports_q.size();
    worked_o    <= worked;
  end

endmodule

// ===== tb/tb.sv =====
// Top of the helix track stepper testbench: clock, reset, stimulus, receiver
// back-pressure and the verdict. Depends on rk4hts_pkg,
// rk4_helix_track_stepper and rk4hts_track_checker.
`timescale 1ns / 1ps

module tb;
  import rk4hts_pkg::*;

  localparam logic [CFG_W-1:0] CFG_SPARE = 3'd7;   // no register behind it
  localparam int     ITEM_TARGET  = 1150;
  localparam int     DRAIN_CYCLES = 200;
  localparam int     HOLD_CYCLES  = 3000;
  localparam longint Q_MAX = (longint'(1) << (DATA_W - 1)) - 1;
  localparam longint Q_MIN = -(longint'(1) << (DATA_W - 1));
  localparam longint H_MAX = (longint'(1) << HSTEP_W) - 1;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_idx;
  logic [DATA_W-1:0] cfg_data;

  int err_count;
  int pending;
  int worked;
  int idle_pct = 11;
  int hold_cycles_req = 0;
  int phase_no;

  always #10 clk_i = ~clk_i;

  rk4_helix_track_stepper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  rk4hts_track_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .err_count_o (err_count),
    .pending_o   (pending),
    .worked_o    (worked)
  );

  function automatic logic [DATA_W-1:0] any_word();
    return DATA_W'({$urandom, $urandom});
  endfunction

  // signed value with magnitude below 2^bits
  function automatic longint spread(input int bits);
    longint m;
    m = longint'({$urandom, $urandom}) & ((longint'(1) << bits) - 1);
    return ($urandom_range(1) != 0) ? -m : m;
  endfunction

  function automatic in_item_t make_item(input bit s, input longint x, input longint y,
                                         input longint z);
    in_item_t it;
    it.start_req = s;
    it.start_x   = word_t'(x);
    it.start_y   = word_t'(y);
    it.start_z   = word_t'(z);
    return it;
  endfunction

  function automatic in_item_t tick_item();
    return make_item(1'b0, any_word(), any_word(), any_word());
  endfunction

  // offer one item, hold it until the transfer, then maybe go quiet a while
  task automatic push_item(input in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  task automatic cfg_write(input logic [CFG_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    @(posedge clk_i);
  endtask

  // sender pauses until every report is in, then lets a silent step finish
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] pick_interval();
    case ($urandom_range(9))
      0:       return '0;
      1:       return DATA_W'(16'hFFFF);
      2:       return DATA_W'($urandom_range(40, 7));
      default: return DATA_W'($urandom_range(6, 1));
    endcase
  endfunction

  // moderate field, step and speeds so that tracks curl and run a while
  task automatic load_physical_cfg();
    cfg_write(CFG_FIELD_COEF, DATA_W'(spread($urandom_range(34, 28))));
    cfg_write(CFG_STEP_SIZE, DATA_W'(longint'($urandom_range(1 << 28, 1 << 20))));
    cfg_write(CFG_VEL_X_INIT, DATA_W'(spread(36)));
    cfg_write(CFG_VEL_Y_INIT, DATA_W'(spread(36)));
    cfg_write(CFG_VEL_Z_CONST, DATA_W'(spread(34)));
    cfg_write(CFG_SAMPLE_INTV, pick_interval());
    cfg_write(CFG_Z_LIMIT, DATA_W'(longint'($urandom_range(1 << 30, 1 << 22)) << 8));
  endtask

  task automatic load_wild_cfg();
    cfg_write(CFG_FIELD_COEF, any_word());
    cfg_write(CFG_STEP_SIZE, any_word());
    cfg_write(CFG_VEL_X_INIT, any_word());
    cfg_write(CFG_VEL_Y_INIT, any_word());
    cfg_write(CFG_VEL_Z_CONST, any_word());
    cfg_write(CFG_SAMPLE_INTV, any_word());
    cfg_write(CFG_Z_LIMIT, any_word());
    if ($urandom_range(1) != 0) cfg_write(CFG_SPARE, any_word());
  endtask

  task automatic run_track(input int n_ticks);
    if ($urandom_range(5) == 0)
      push_item(make_item(1'b1, any_word(), any_word(), any_word()));
    else
      push_item(make_item(1'b1, spread(40), spread(40), spread(36)));
    repeat (n_ticks) push_item(tick_item());
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles_req != 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles_req) @(posedge clk_i);
        hold_cycles_req = 0;
      end
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  initial begin
    #40_000_000;
    $display("** rk4_helix_track_stepper: FAILED **");
    $finish;
  end

  initial begin
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: a tick with no track is dropped, a still track stays put
    push_item(tick_item());
    push_item(make_item(1'b1, Q_MAX, Q_MIN, 0));
    repeat (3) push_item(tick_item());
    drain_results();

    // every register at an extreme, interval zero reports on every step
    cfg_write(CFG_FIELD_COEF, DATA_W'(Q_MAX));
    cfg_write(CFG_STEP_SIZE, DATA_W'(H_MAX));
    cfg_write(CFG_VEL_X_INIT, DATA_W'(Q_MIN));
    cfg_write(CFG_VEL_Y_INIT, DATA_W'(Q_MAX));
    cfg_write(CFG_VEL_Z_CONST, DATA_W'(Q_MAX));
    cfg_write(CFG_SAMPLE_INTV, '0);
    cfg_write(CFG_Z_LIMIT, DATA_W'(H_MAX));
    push_item(make_item(1'b1, Q_MIN, Q_MAX, Q_MIN));
    repeat (2) push_item(tick_item());
    // restart while the track runs
    push_item(make_item(1'b1, 0, 0, 0));
    repeat (2) push_item(tick_item());
    drain_results();

    // zero z bound ends the track on its first step; spare index is ignored
    cfg_write(CFG_FIELD_COEF, DATA_W'(Q_MIN));
    cfg_write(CFG_VEL_Z_CONST, DATA_W'(Q_MIN));
    cfg_write(CFG_Z_LIMIT, '0);
    cfg_write(CFG_SAMPLE_INTV, DATA_W'(16'hFFFF));
    cfg_write(CFG_SPARE, any_word());
    push_item(make_item(1'b1, Q_MAX, Q_MIN, Q_MAX));
    repeat (2) push_item(tick_item());
    drain_results();

    // interval dropped below the running phase: next step reports
    load_physical_cfg();
    cfg_write(CFG_SAMPLE_INTV, DATA_W'(20));
    cfg_write(CFG_Z_LIMIT, DATA_W'(H_MAX));
    run_track(6);
    drain_results();
    cfg_write(CFG_SAMPLE_INTV, DATA_W'(2));
    repeat (3) push_item(tick_item());

    // random phases, mostly well-formed tracks
    phase_no = 0;
    while (worked < ITEM_TARGET) begin
      drain_results();
      idle_pct = (phase_no >= 12 && phase_no < 18) ? 0 : 11;
      if (phase_no == 6) begin
        // long receiver hold-off with a report per step fills the block
        cfg_write(CFG_SAMPLE_INTV, DATA_W'(1));
        cfg_write(CFG_Z_LIMIT, DATA_W'(H_MAX));
        hold_cycles_req = HOLD_CYCLES;
        run_track(30);
      end else begin
        case ($urandom_range(7))
          0: begin
            load_wild_cfg();
            run_track($urandom_range(25, 3));
          end
          1, 2: begin
            // retune mid-track and carry on stepping
            cfg_write(CFG_SAMPLE_INTV, pick_interval());
            if ($urandom_range(1) != 0)
              cfg_write(CFG_FIELD_COEF, DATA_W'(spread($urandom_range(34, 28))));
            repeat ($urandom_range(20, 3)) push_item(tick_item());
          end
          3: begin
            load_physical_cfg();
            repeat (12)
              push_item(make_item($urandom_range(5) == 0, any_word(), any_word(),
                                  any_word()));
          end
          default: begin
            load_physical_cfg();
            run_track($urandom_range(40, 5));
          end
        endcase
      end
      phase_no++;
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && pending == 0)
      $display("** rk4_helix_track_stepper: PASSED **");
    else
      $display("** rk4_helix_track_stepper: FAILED **");
    $finish;
  end

endmodule
